FILE: sv/lsh_pkg.sv
package lsh_pkg;

  localparam int LAT_W               = 48;
  localparam int VAL_W               = 64;
  localparam int IDX_W               = 6;
  localparam int LOG2_W              = 6;
  localparam int BKT_FIELD_W         = 5;
  localparam int LATENCY_BUCKETS_DEF = 32;
  localparam int FIRST_BUCKET_IDX    = 4;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  localparam logic [IDX_W-1:0] STAT_SUCCESS = IDX_W'(0);
  localparam logic [IDX_W-1:0] STAT_FAILURE = IDX_W'(1);
  localparam logic [IDX_W-1:0] STAT_TOTAL   = IDX_W'(2);
  localparam logic [IDX_W-1:0] STAT_MAX     = IDX_W'(3);

  // floor(log2(v)), zero for v of zero or one
  function automatic logic [LOG2_W-1:0] floor_log2(input logic [LAT_W-1:0] v);
    logic [LOG2_W-1:0] r;
    r = '0;
    for (int i = 1; i < LAT_W; i++) begin
      if (v[i]) begin
        r = LOG2_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/lsh_bucket_ram.sv
module lsh_bucket_ram #(
  parameter int DEPTH = lsh_pkg::LATENCY_BUCKETS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [lsh_pkg::VAL_W-1:0] wr_data,
  output logic [lsh_pkg::VAL_W-1:0] rd_data
);
  import lsh_pkg::*;

  logic [VAL_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [VAL_W-1:0] mem_q_r;
  logic [VAL_W-1:0] fwd_data_r;
  logic             vld_q_r;
  logic             hit_r;

  // storage and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r    <= mem_r[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // per-entry valid bits, write-to-read bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= vld_r[rd_addr];
        hit_r   <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = hit_r ? fwd_data_r : (vld_q_r ? mem_q_r : '0);

endmodule

FILE: sv/latency_stats_histogram.sv
// Latency statistics monitor. A record item (in_tuser = 0) counts one operation as a success
// or failure, adds its duration to a 64-bit total, updates the largest duration and bumps the
// log2 histogram bucket floor(log2(duration)), capped at the last bucket; its result carries
// that bucket number and a zero value. A read item (in_tuser = 1) returns the statistic picked
// by stat_index (0 successes, 1 failures, 2 total, 3 maximum, 4 and up buckets, zero beyond)
// with a zero bucket field. One result per item, one item per cycle sustained while out_tready
// holds; out_tvalid is registered behind s1. The rate rests on the read-modify-write of the
// bucket counter memory, which bypasses a write to a read of the same bucket in the next item.
// All statistics read zero right after reset, with no clearing pass; counters wrap at 2^64.
module latency_stats_histogram #(
  parameter int LATENCY_BUCKETS = lsh_pkg::LATENCY_BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lsh_pkg::IN_TDATA_W-1:0] in_tdata,   // latency_ns, failed, stat_index
  input  logic                           in_tuser,   // cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lsh_pkg::OUT_TDATA_W-1:0] out_tdata  // stat_value, bucket
);
  import lsh_pkg::*;

  localparam int AW = $clog2(LATENCY_BUCKETS);

  logic [LAT_W-1:0]  in_lat;
  logic              in_failed;
  logic [IDX_W-1:0]  in_idx;
  logic [LOG2_W-1:0] in_log2;
  logic [AW-1:0]     in_bkt;
  logic [IDX_W-1:0]  in_rel;
  logic [AW-1:0]     rd_addr;
  logic              in_acc;

  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  logic [LAT_W-1:0]  s1_lat_r;
  logic              s1_failed_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [AW-1:0]     s1_bkt_r;
  logic              s1_adv;

  logic [VAL_W-1:0]  succ_r;
  logic [VAL_W-1:0]  fail_r;
  logic [VAL_W-1:0]  total_r;
  logic [LAT_W-1:0]  max_r;

  logic              wr_en;
  logic [VAL_W-1:0]  bkt_cnt;
  logic [IDX_W:0]    s1_rel;
  logic              s1_in_range;
  logic [VAL_W-1:0]  stat_val;
  logic [BKT_FIELD_W-1:0] res_bkt;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_val_r;
  logic [BKT_FIELD_W-1:0] out_bkt_r;

  assign in_lat    = in_tdata[LAT_W-1:0];
  assign in_failed = in_tdata[LAT_W];
  assign in_idx    = in_tdata[LAT_W+1+:IDX_W];

  assign in_log2 = floor_log2(in_lat);
  assign in_bkt  = (in_log2 > LOG2_W'(LATENCY_BUCKETS - 1)) ? AW'(LATENCY_BUCKETS - 1)
                                                            : AW'(in_log2);
  assign in_rel  = in_idx - IDX_W'(FIRST_BUCKET_IDX);
  assign rd_addr = (in_tuser == CMD_READ) ? AW'(in_rel) : in_bkt;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= cmd_t'(in_tuser);
      s1_lat_r    <= in_lat;
      s1_failed_r <= in_failed;
      s1_idx_r    <= in_idx;
      s1_bkt_r    <= in_bkt;
    end
  end

  assign wr_en = s1_adv && (s1_cmd_r == CMD_RECORD);

  lsh_bucket_ram #(
    .DEPTH (LATENCY_BUCKETS),
    .AW    (AW)
  ) u_bkt_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_bkt_r),
    .wr_data (bkt_cnt + VAL_W'(1)),
    .rd_data (bkt_cnt)
  );

  // scalar statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      succ_r  <= '0;
      fail_r  <= '0;
      total_r <= '0;
      max_r   <= '0;
    end else if (wr_en) begin
      if (s1_failed_r) begin
        fail_r <= fail_r + VAL_W'(1);
      end else begin
        succ_r <= succ_r + VAL_W'(1);
      end
      total_r <= total_r + VAL_W'(s1_lat_r);
      if (s1_lat_r > max_r) begin
        max_r <= s1_lat_r;
      end
    end
  end

  assign s1_rel      = {1'b0, s1_idx_r} - (IDX_W+1)'(FIRST_BUCKET_IDX);
  assign s1_in_range = (s1_idx_r >= IDX_W'(FIRST_BUCKET_IDX)) &&
                       (s1_rel < (IDX_W+1)'(LATENCY_BUCKETS));

  always_comb begin
    stat_val = '0;
    res_bkt  = '0;
    if (s1_cmd_r == CMD_READ) begin
      case (s1_idx_r)
        STAT_SUCCESS: stat_val = succ_r;
        STAT_FAILURE: stat_val = fail_r;
        STAT_TOTAL:   stat_val = total_r;
        STAT_MAX:     stat_val = VAL_W'(max_r);
        default: begin
          if (s1_in_range) begin
            stat_val = bkt_cnt;
          end
        end
      endcase
    end else begin
      res_bkt = BKT_FIELD_W'(LOG2_W'(s1_bkt_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_val_r <= stat_val;
      out_bkt_r <= res_bkt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - VAL_W - BKT_FIELD_W)'(0), out_bkt_r, out_val_r};

  a_rec_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_RECORD) |=>
      (succ_r + fail_r) == ($past(succ_r) + $past(fail_r) + VAL_W'(1)))
    else $error("record did not bump exactly one of the outcome counters");

  a_read_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_READ) |=>
      ($stable(succ_r) && $stable(fail_r) && $stable(total_r) && $stable(max_r)))
    else $error("read changed statistics");

  a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_RECORD) |=> (max_r >= $past(s1_lat_r)))
    else $error("maximum below recorded duration");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule
